### rtl/stdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdq_pkg
// Types and codes shared by the ordered timer queue modules.
// ----------------------------------------------------------------------------
package stdq_pkg;

  localparam int DL_W = 48;
  localparam int ID_W = 16;

  // Operation codes of an input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EXPIRE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_INSERT  = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  // Insert status codes.
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;

  typedef struct packed {
    logic            op;
    logic [DL_W-1:0] deadline;
    logic [ID_W-1:0] timer_id;
    logic [DL_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      status;
    logic            earliest_changed;
    logic [DL_W-1:0] arm_delay;
    logic [ID_W-1:0] expired_id;
    logic [DL_W-1:0] expired_deadline;
    logic            last;
  } out_item_t;

  // One stored timer.
  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

### rtl/stdq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stdq_mem #(
  parameter int CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  stdq_pkg::entry_t            wr_data,
  input  logic                        rd_en,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output stdq_pkg::entry_t            rd_data
);

  stdq_pkg::entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads, so a stalled consumer sees it unchanged.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/stdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stdq_ctrl
// Sequencer for the ordered timer queue: scan, shift and expire passes.
// ----------------------------------------------------------------------------
module stdq_ctrl #(
  parameter int CAPACITY      = 16,
  parameter int MIN_ARM_DELAY = 100
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  stdq_pkg::in_item_t          in_data,
  input  logic                        slot_free,
  output logic                        res_push,
  output stdq_pkg::out_item_t         res_data,
  output logic                        mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
  output stdq_pkg::entry_t            mem_wr_data,
  output logic                        mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
  input  stdq_pkg::entry_t            mem_rd_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]             CAP_S   = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0]           CAP_C   = CW'(CAPACITY);
  localparam logic [stdq_pkg::DL_W-1:0] MIN_DLY = stdq_pkg::DL_W'(MIN_ARM_DELAY);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS_SCAN = 7'b0000010,
    S_INS_DEC  = 7'b0000100,
    S_INS_SHFT = 7'b0001000,
    S_INS_PUT  = 7'b0010000,
    S_INS_RESP = 7'b0100000,
    S_EXP_CHK  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  stdq_pkg::in_item_t  req_r, req_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                first_r, first_nxt;
  logic                dup_r, dup_nxt;
  logic                chg_r, chg_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       src_r, src_nxt;
  logic [CW-1:0]       wr_tgt_r, wr_tgt_nxt;
  stdq_pkg::entry_t    pend_r, pend_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  stdq_pkg::out_item_t res_r, res_nxt;

  logic [IW-1:0]             head_inc;
  logic                      key_eq, key_lt, due;
  logic [stdq_pkg::DL_W-1:0] diff, arm;

  // Logical table position to physical address in the circular store.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base,
                                         input logic [CW-1:0] j);
    logic [IW:0] s;
    s = {1'b0, base} + (IW + 1)'(j);
    if (s >= CAP_S) begin
      s = s - CAP_S;
    end
    return s[IW-1:0];
  endfunction

  assign head_inc = phys(head_r, CW'(1));

  assign key_eq = (mem_rd_data.deadline == req_r.deadline) && (mem_rd_data.id == req_r.timer_id);
  assign key_lt = (mem_rd_data.deadline < req_r.deadline) ||
                  ((mem_rd_data.deadline == req_r.deadline) &&
                   (mem_rd_data.id < req_r.timer_id));
  assign due    = (cnt_r != '0) && (mem_rd_data.deadline <= req_r.now);

  assign diff = req_r.deadline - req_r.now;
  assign arm  = ((req_r.deadline > req_r.now) && (diff >= MIN_DLY)) ? diff : MIN_DLY;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = 1'b0;
    first_nxt    = first_r;
    dup_nxt      = dup_r;
    chg_nxt      = chg_r;
    pos_nxt      = pos_r;
    src_nxt      = src_r;
    wr_tgt_nxt   = wr_tgt_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    res_nxt      = res_r;
    res_push     = 1'b0;
    res_data     = '0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = phys(head_r, wr_tgt_r);
    mem_wr_data  = mem_rd_data;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          rd_idx_nxt   = '0;
          first_nxt    = 1'b1;
          dup_nxt      = 1'b0;
          chg_nxt      = 1'b1;
          pos_nxt      = '0;
          pend_vld_nxt = 1'b0;
          if (in_data.op == stdq_pkg::OP_EXPIRE) begin
            mem_rd_en = 1'b1;
            state_nxt = S_EXP_CHK;
          end else begin
            state_nxt = S_INS_SCAN;
          end
        end
      end

      // One read issued per cycle; the compare uses its data in the cycle after.
      S_INS_SCAN: begin
        if (rd_idx_r < cnt_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = phys(head_r, rd_idx_r);
          rd_idx_nxt  = rd_idx_r + CW'(1);
          rd_vld_nxt  = 1'b1;
        end
        if (rd_vld_r) begin
          if (key_eq) begin
            dup_nxt = 1'b1;
          end
          if (key_lt) begin
            pos_nxt = pos_r + CW'(1);
          end
          if (first_r) begin
            chg_nxt   = req_r.deadline < mem_rd_data.deadline;
            first_nxt = 1'b0;
          end
        end
        if ((rd_idx_r == cnt_r) && !rd_vld_r) begin
          state_nxt = S_INS_DEC;
        end
      end

      S_INS_DEC: begin
        res_nxt      = '0;
        res_nxt.kind = stdq_pkg::KIND_INSERT;
        res_nxt.last = 1'b1;
        if (dup_r) begin
          res_nxt.status = stdq_pkg::ST_DUP;
          state_nxt      = S_INS_RESP;
        end else if (cnt_r == CAP_C) begin
          res_nxt.status = stdq_pkg::ST_FULL;
          state_nxt      = S_INS_RESP;
        end else begin
          src_nxt   = cnt_r;
          state_nxt = S_INS_SHFT;
        end
      end

      // Move entries at and above the insert position up by one, tail first.
      S_INS_SHFT: begin
        if (src_r > pos_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = phys(head_r, src_r - CW'(1));
          src_nxt     = src_r - CW'(1);
          wr_tgt_nxt  = src_r;
          rd_vld_nxt  = 1'b1;
        end
        if (rd_vld_r) begin
          mem_wr_en = 1'b1;
        end
        if ((src_r == pos_r) && !rd_vld_r) begin
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        mem_wr_en            = 1'b1;
        mem_wr_addr          = phys(head_r, pos_r);
        mem_wr_data.deadline = req_r.deadline;
        mem_wr_data.id       = req_r.timer_id;
        cnt_nxt              = cnt_r + CW'(1);
        res_nxt.status           = stdq_pkg::ST_ACCEPTED;
        res_nxt.earliest_changed = chg_r;
        res_nxt.arm_delay        = chg_r ? arm : '0;
        state_nxt                = S_INS_RESP;
      end

      S_INS_RESP: begin
        if (slot_free) begin
          res_push  = 1'b1;
          res_data  = res_r;
          state_nxt = S_IDLE;
        end
      end

      // The head entry is checked; a due one is held back until the next
      // check tells whether it is the final transfer of this expire.
      S_EXP_CHK: begin
        if (due) begin
          if (!pend_vld_r || slot_free) begin
            if (pend_vld_r) begin
              res_push                  = 1'b1;
              res_data.kind             = stdq_pkg::KIND_EXPIRED;
              res_data.expired_id       = pend_r.id;
              res_data.expired_deadline = pend_r.deadline;
            end
            pend_nxt     = mem_rd_data;
            pend_vld_nxt = 1'b1;
            head_nxt     = head_inc;
            cnt_nxt      = cnt_r - CW'(1);
            mem_rd_en    = 1'b1;
            mem_rd_addr  = head_inc;
          end
        end else if (slot_free) begin
          res_push      = 1'b1;
          res_data.last = 1'b1;
          if (pend_vld_r) begin
            res_data.kind             = stdq_pkg::KIND_EXPIRED;
            res_data.expired_id       = pend_r.id;
            res_data.expired_deadline = pend_r.deadline;
          end else begin
            res_data.kind = stdq_pkg::KIND_NONE;
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      head_r     <= '0;
      rd_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      head_r     <= head_nxt;
      rd_vld_r   <= rd_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    rd_idx_r <= rd_idx_nxt;
    first_r  <= first_nxt;
    dup_r    <= dup_nxt;
    chg_r    <= chg_nxt;
    pos_r    <= pos_nxt;
    src_r    <= src_nxt;
    wr_tgt_r <= wr_tgt_nxt;
    pend_r   <= pend_nxt;
    res_r    <= res_nxt;
  end

endmodule

### rtl/sorted_timer_deadline_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_deadline_queue_unit
// Ordered timer queue keyed by deadline, then timer id.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one operation at a time:
// an insert of a (deadline, timer_id) pair, or an expire of everything due
// at now. Each insert gives exactly one result transfer; an expire gives one
// transfer per expired entry, in order, with last set on the final one, or
// a single "nothing expired" transfer.
// Entries sit in one circular memory with a registered read.
// An accepted insert makes two passes over the N stored entries: one
// pass reads all entries for the duplicate check and the insert position, a
// second pass moves the entries at and above that position up one place
// through the single write port. A rejected insert makes only the first pass.
// An expire reads the memory once per entry checked.
// in_ready is high only while no operation is in progress.
// Reset empties the table at once; no clearing pass is needed.
// A stalled receiver holds the result in the output register, and the
// sequencer waits until that register is free before the next transfer.
// ----------------------------------------------------------------------------
module sorted_timer_deadline_queue_unit #(
  parameter int CAPACITY      = 16,
  parameter int MIN_ARM_DELAY = 100
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  stdq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output stdq_pkg::out_item_t out_data
);

  localparam int IW = $clog2(CAPACITY);

  logic                out_valid_r;
  stdq_pkg::out_item_t out_data_r;
  logic                slot_free;
  logic                res_push;
  stdq_pkg::out_item_t res_data;

  logic             mem_wr_en;
  logic [IW-1:0]    mem_wr_addr;
  stdq_pkg::entry_t mem_wr_data;
  logic             mem_rd_en;
  logic [IW-1:0]    mem_rd_addr;
  stdq_pkg::entry_t mem_rd_data;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  stdq_ctrl #(
    .CAPACITY      (CAPACITY),
    .MIN_ARM_DELAY (MIN_ARM_DELAY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .slot_free   (slot_free),
    .res_push    (res_push),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  stdq_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_data_r <= res_data;
    end
  end

endmodule
